FILE: design/swin_pkg.sv
// Shared types and constants for the selective-repeat receive window.
// Used by swin_mod_unit and selective_repeat_receive_window; no dependencies.
package swin_pkg;

   localparam int SEQ_COUNT = 20;  // size of the sequence space
   localparam int SEQ_W     = $clog2(SEQ_COUNT + 1);  // width of the one-based sequence fields
   localparam int PAYLOAD_W = 32;  // width of the payload word
   localparam int WIN_W     = 4;   // width of the window_size register
   localparam int CNT_W     = 4;   // delivery counter, holds up to WIN_MAX

   localparam int WIN_MAX   = 10;  // hard cap on the window and on deliveries
   localparam logic [WIN_W-1:0] WIN_RESET = 4'd10;

   // result_kind codes
   localparam logic RESULT_DELIVER = 1'b0;
   localparam logic RESULT_ACK     = 1'b1;

   // operations of the shared modular unit
   typedef enum logic {
      MOD_OP_SUB = 1'b0,  // (a - b) mod SEQ_COUNT
      MOD_OP_INC = 1'b1   // (a + 1) mod SEQ_COUNT
   } mod_op_type;

endpackage

FILE: design/swin_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module swin_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 20
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // hold the last read word until the next read
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/swin_mod_unit.sv
// Shared modular arithmetic unit over the sequence space: distance and increment.
// Depends on swin_pkg.
module swin_mod_unit #(
   parameter int SEQ_COUNT = 20
) (
   input  swin_pkg::mod_op_type         op,
   input  logic [$clog2(SEQ_COUNT)-1:0] a,
   input  logic [$clog2(SEQ_COUNT)-1:0] b,
   output logic [$clog2(SEQ_COUNT)-1:0] y
);

   localparam int IDX_W = $clog2(SEQ_COUNT);
   localparam logic [IDX_W:0] SEQ_EXT  = (IDX_W+1)'(SEQ_COUNT);
   localparam logic [IDX_W-1:0] SEQ_TOP = IDX_W'(SEQ_COUNT - 1);

   logic [IDX_W:0] diff;

   always_comb begin
      diff = {1'b0, a} - {1'b0, b};
      case (op)
         swin_pkg::MOD_OP_SUB: begin
            // wrap a negative difference back into the sequence space
            if (a < b) begin
               y = IDX_W'(diff + SEQ_EXT);
            end else begin
               y = diff[IDX_W-1:0];
            end
         end
         swin_pkg::MOD_OP_INC: begin
            if (a == SEQ_TOP) begin
               y = '0;
            end else begin
               y = a + IDX_W'(1);
            end
         end
         default: begin
            y = '0;
         end
      endcase
   end

endmodule

FILE: design/selective_repeat_receive_window.sv
// Selective-repeat receive window: buffers out-of-order frames, releases them in order.
// Depends on swin_pkg, swin_mod_unit and swin_ram.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_ready  frame_seq, frame_payload
//   rsp      out        rsp_valid/rsp_ready  kind, seq, payload, in-window, last
//   csr      in         csr_wr_en            window_size (4 bits)
//
// A frame that releases nothing passes accept, window check and ack; one that
// releases buffered frames adds a payload RAM read after the check, then delivers
// them one per cycle while rsp is not stalled. The shared modular unit and the single
// RAM read port set this pacing. req_ready is high only while the sequencer is idle.
// A stalled rsp channel holds the sequencer in place. Synchronous reset clears
// the slot flags, the base and the window register (to 10); the RAM is not cleared.
module selective_repeat_receive_window (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [swin_pkg::SEQ_W-1:0]          req_frame_seq,
   input  logic [swin_pkg::PAYLOAD_W-1:0]      req_frame_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_result_kind,
   output logic [swin_pkg::SEQ_W-1:0]          rsp_result_seq,
   output logic [swin_pkg::PAYLOAD_W-1:0]      rsp_delivered_payload,
   output logic                                rsp_was_in_window,
   output logic                                rsp_last_result,
   input  logic                                csr_wr_en,
   input  logic [swin_pkg::WIN_W-1:0]          csr_wr_data
);

   localparam int SEQ_COUNT = swin_pkg::SEQ_COUNT;
   localparam int IDX_W   = $clog2(SEQ_COUNT);
   localparam int WIN_CAP = (swin_pkg::WIN_MAX < SEQ_COUNT / 2) ?
                            swin_pkg::WIN_MAX : SEQ_COUNT / 2;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_DIST  = 3'd1;
   localparam logic [2:0] ST_LOOK  = 3'd2;
   localparam logic [2:0] ST_DELIV = 3'd3;
   localparam logic [2:0] ST_ACK   = 3'd4;

   logic [2:0]                      state_ff, state_in;
   logic [swin_pkg::WIN_W-1:0]      win_ff, win_in;
   logic [IDX_W-1:0]                base_ff, base_in;
   logic [SEQ_COUNT-1:0]            used_ff, used_in;
   logic [swin_pkg::CNT_W-1:0]      count_ff, count_in;
   logic                            in_win_ff, in_win_in;
   logic                            rsp_valid_ff, rsp_valid_in;

   logic [swin_pkg::SEQ_W-1:0]      seq_ff;
   logic [swin_pkg::PAYLOAD_W-1:0]  payload_ff;
   logic [IDX_W-1:0]                idx_ff;
   logic                            in_range_ff;

   logic                            rsp_kind_ff, rsp_kind_in;
   logic [swin_pkg::SEQ_W-1:0]      rsp_seq_ff, rsp_seq_in;
   logic [swin_pkg::PAYLOAD_W-1:0]  rsp_payload_ff, rsp_payload_in;
   logic                            rsp_inwin_ff, rsp_inwin_in;
   logic                            rsp_last_ff, rsp_last_in;
   logic                            rsp_load;

   swin_pkg::mod_op_type            unit_op;
   logic [IDX_W-1:0]                unit_a, unit_y;

   logic                            ram_wr_en, ram_rd_en;
   logic [IDX_W-1:0]                ram_rd_addr;
   logic [swin_pkg::PAYLOAD_W-1:0]  ram_rd_data;

   logic                            req_accept, out_free, in_win_now;
   logic [swin_pkg::WIN_W-1:0]      eff_win;

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_accept = req_valid && req_ready;
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign eff_win    = (32'(win_ff) > WIN_CAP) ? swin_pkg::WIN_W'(WIN_CAP) : win_ff;

   // distance from the base in the check state, base increment otherwise
   assign unit_op = (state_ff == ST_DIST) ? swin_pkg::MOD_OP_SUB : swin_pkg::MOD_OP_INC;
   assign unit_a  = (state_ff == ST_DIST) ? idx_ff : base_ff;

   swin_mod_unit #(
      .SEQ_COUNT (SEQ_COUNT)
   ) u_mod (
      .op (unit_op),
      .a  (unit_a),
      .b  (base_ff),
      .y  (unit_y)
   );

   assign in_win_now = in_range_ff && (32'(unit_y) < 32'(eff_win));
   assign ram_wr_en  = (state_ff == ST_DIST) && in_win_now && !used_ff[idx_ff];
   assign ram_rd_addr = (state_ff == ST_DELIV) ? unit_y : base_ff;

   swin_ram #(
      .WIDTH (swin_pkg::PAYLOAD_W),
      .DEPTH (SEQ_COUNT)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (idx_ff),
      .wr_data (payload_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      state_in       = state_ff;
      win_in         = win_ff;
      base_in        = base_ff;
      used_in        = used_ff;
      count_in       = count_ff;
      in_win_in      = in_win_ff;
      ram_rd_en      = 1'b0;
      rsp_load       = 1'b0;
      rsp_kind_in    = rsp_kind_ff;
      rsp_seq_in     = rsp_seq_ff;
      rsp_payload_in = rsp_payload_ff;
      rsp_inwin_in   = rsp_inwin_ff;
      rsp_last_in    = rsp_last_ff;

      if (csr_wr_en) begin
         win_in = csr_wr_data;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_DIST;
            end
         end
         ST_DIST: begin
            in_win_in = in_win_now;
            if (ram_wr_en) begin
               used_in[idx_ff] = 1'b1;
            end
            if (in_win_now && (unit_y == '0)) begin
               state_in = ST_LOOK;
            end else begin
               state_in = ST_ACK;
            end
         end
         ST_LOOK: begin
            // the expected slot holds a buffered frame: fetch it
            ram_rd_en = 1'b1;
            count_in  = '0;
            state_in  = ST_DELIV;
         end
         ST_DELIV: begin
            if (out_free) begin
               rsp_load         = 1'b1;
               rsp_kind_in      = swin_pkg::RESULT_DELIVER;
               rsp_seq_in       = swin_pkg::SEQ_W'(32'(base_ff) + 1);
               rsp_payload_in   = ram_rd_data;
               rsp_inwin_in     = 1'b1;
               rsp_last_in      = 1'b0;
               used_in[base_ff] = 1'b0;
               base_in          = unit_y;
               count_in         = count_ff + swin_pkg::CNT_W'(1);
               // prefetch the next slot when it is also buffered and the delivery cap is not reached
               if (used_ff[unit_y] && (32'(count_ff) + 1 < swin_pkg::WIN_MAX)) begin
                  ram_rd_en = 1'b1;
               end else begin
                  state_in = ST_ACK;
               end
            end
         end
         ST_ACK: begin
            if (out_free) begin
               rsp_load       = 1'b1;
               rsp_kind_in    = swin_pkg::RESULT_ACK;
               rsp_seq_in     = seq_ff;
               rsp_payload_in = '0;
               rsp_inwin_in   = in_win_ff;
               rsp_last_in    = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         win_ff       <= swin_pkg::WIN_RESET;
         base_ff      <= '0;
         used_ff      <= '0;
         count_ff     <= '0;
         in_win_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         win_ff       <= win_in;
         base_ff      <= base_in;
         used_ff      <= used_in;
         count_ff     <= count_in;
         in_win_ff    <= in_win_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         seq_ff      <= req_frame_seq;
         payload_ff  <= req_frame_payload;
         idx_ff      <= IDX_W'(32'(req_frame_seq) - 1);
         in_range_ff <= (req_frame_seq != '0) && (32'(req_frame_seq) <= SEQ_COUNT);
      end
      rsp_kind_ff    <= rsp_kind_in;
      rsp_seq_ff     <= rsp_seq_in;
      rsp_payload_ff <= rsp_payload_in;
      rsp_inwin_ff   <= rsp_inwin_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_result_kind       = rsp_kind_ff;
   assign rsp_result_seq        = rsp_seq_ff;
   assign rsp_delivered_payload = rsp_payload_ff;
   assign rsp_was_in_window     = rsp_inwin_ff;
   assign rsp_last_result       = rsp_last_ff;

endmodule
